>>> hw/rtl/elm_pkg.sv
// elm_pkg: shared constants, types and codes for the event latency monitor
// used by elm_table, elm_div and event_latency_monitor; no dependencies
package elm_pkg;

    localparam int ENTRIES_PER_CLASS = 16;
    localparam int TOTAL_ENTRIES     = 2 * ENTRIES_PER_CLASS;
    localparam int IDX_W             = (ENTRIES_PER_CLASS > 1) ? $clog2(ENTRIES_PER_CLASS) : 1;
    localparam int ADDR_W            = $clog2(TOTAL_ENTRIES);

    localparam int ID_W   = 32;
    localparam int TIME_W = 48;
    localparam int LAT_W  = 32;
    localparam int SUM_W  = 2 * LAT_W;
    localparam int DIV_CNT_W = $clog2(LAT_W + 1);

    localparam logic REQ_START    = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    typedef enum logic [1:0] {
        STAT_STORED    = 2'd0,
        STAT_MEASURED  = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   tag;
        logic [TIME_W-1:0] start;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_tbl_wr;

endpackage

>>> hw/rtl/elm_table.sv
// elm_table: id tag and start time memory for both classes, with per-entry valid bits
// one write port and one registered read port; depends on elm_pkg
module elm_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic [elm_pkg::ADDR_W-1:0]         i_rd_addr,
    input  elm_pkg::t_tbl_wr                   i_wr,
    output elm_pkg::t_entry                    o_rd_data,
    output logic [elm_pkg::TOTAL_ENTRIES-1:0]  o_valid
);
    import elm_pkg::*;

    t_entry                   mem [TOTAL_ENTRIES];
    t_entry                   r_rd_data;
    logic [TOTAL_ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;

endmodule

>>> hw/rtl/elm_div.sv
// elm_div: radix-2 restoring divider for the class average, one quotient bit per cycle
// quotient clamped to all ones, zero for a zero divisor; depends on elm_pkg
module elm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [elm_pkg::SUM_W-1:0] i_dividend,
    input  logic [elm_pkg::LAT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [elm_pkg::LAT_W-1:0] o_quot
);
    import elm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LAT_W-1:0]     r_rem;
    logic [LAT_W-1:0]     r_quot;
    logic [LAT_W-1:0]     r_den;
    logic [LAT_W:0]       trial;
    logic [LAT_W:0]       diff;
    logic                 ge;

    assign trial = {r_rem, r_quot[LAT_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_divisor == '0 || i_dividend[SUM_W-1:LAT_W] >= i_divisor) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= DIV_CNT_W'(LAT_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            if (i_divisor == '0) begin
                r_quot <= '0;
            end else if (i_dividend[SUM_W-1:LAT_W] >= i_divisor) begin
                r_quot <= '1;
            end else begin
                r_rem  <= i_dividend[SUM_W-1:LAT_W];
                r_quot <= i_dividend[LAT_W-1:0];
            end
        end else if (r_busy) begin
            r_rem  <= ge ? diff[LAT_W-1:0] : trial[LAT_W-1:0];
            r_quot <= {r_quot[LAT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hw/rtl/event_latency_monitor.sv
// event_latency_monitor: top level with the request sequencer and per-class statistics
// instantiates elm_table and elm_div; depends on elm_pkg
//
// One request at a time: start requests store a start time under an id, complete
// requests look the id up and report the latency and the class count, min, max and
// average. The tag search reads one table entry per cycle through the single memory
// read port and stops at the first match, and the average comes from a 32-step
// shift-subtract divider that skips its steps when the count is zero or the average
// clamps. The input stalls while a request is in work; a finished result sits in the
// output register, so the next request is taken while it waits. Reset clears all
// valid bits and statistics at once.
module event_latency_monitor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_req_type,
    input  logic                       i_event_class,
    input  logic [elm_pkg::ID_W-1:0]   i_event_id,
    input  logic [elm_pkg::TIME_W-1:0] i_time_us,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [elm_pkg::LAT_W-1:0]  o_latency_us,
    output logic [elm_pkg::LAT_W-1:0]  o_class_count,
    output logic [elm_pkg::LAT_W-1:0]  o_class_min_us,
    output logic [elm_pkg::LAT_W-1:0]  o_class_max_us,
    output logic [elm_pkg::LAT_W-1:0]  o_class_avg_us
);
    import elm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SEARCH   = 6'b000010,
        S_PROC     = 6'b000100,
        S_DIV_GO   = 6'b001000,
        S_DIV_WAIT = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic cls,
                                                     input logic [IDX_W-1:0] idx);
        entry_addr = ADDR_W'(cls) * ADDR_W'(ENTRIES_PER_CLASS) + ADDR_W'(idx);
    endfunction

    t_state             r_state, n_state;
    logic               r_req;
    logic               r_cls;
    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_time;
    logic [IDX_W:0]     r_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [TIME_W-1:0]  r_start;
    t_status            r_status, n_status;
    logic [LAT_W-1:0]   r_lat, n_lat;
    logic [LAT_W-1:0]   r_avg;

    logic [LAT_W-1:0]   r_cnt [2];
    logic [SUM_W-1:0]   r_sum [2];
    logic [LAT_W-1:0]   r_min [2];
    logic [LAT_W-1:0]   r_max [2];

    logic               r_out_valid;
    t_status            r_o_status;
    logic [LAT_W-1:0]   r_o_lat, r_o_cnt, r_o_min, r_o_max, r_o_avg;

    logic               in_acc;
    logic               out_free;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    t_entry             rd_data;
    logic [TOTAL_ENTRIES-1:0] valid;
    logic               hit_now;
    logic               last_cmp;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [TIME_W-1:0]  diff;
    logic [LAT_W-1:0]   lat;
    logic [SUM_W:0]     sum_ext;
    logic               stat_upd;
    logic [LAT_W-1:0]   cur_cnt, cur_min, cur_max;
    logic [SUM_W-1:0]   cur_sum;
    logic [LAT_W-1:0]   n_cnt, n_min, n_max;
    logic [SUM_W-1:0]   n_sum;
    t_tbl_wr            tbl_wr;
    logic               div_start;
    logic               div_done;
    logic [LAT_W-1:0]   div_quot;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // table search, one entry per cycle, compare in the cycle after the read
    assign rd_en    = (r_state == S_SEARCH) && (r_idx < (IDX_W + 1)'(ENTRIES_PER_CLASS));
    assign rd_addr  = entry_addr(r_cls, r_idx[IDX_W-1:0]);
    assign hit_now  = (r_state == S_SEARCH) && r_cmp_vld
                      && valid[entry_addr(r_cls, r_cmp_idx)] && (rd_data.tag == r_id);
    assign last_cmp = r_cmp_vld && (r_cmp_idx == IDX_W'(ENTRIES_PER_CLASS - 1));

    // lowest free entry of the class
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES_PER_CLASS - 1; i >= 0; i--) begin
            if (!valid[entry_addr(r_cls, IDX_W'(i))]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // latency modulo the timer width, saturated
    assign diff = r_time - r_start;
    assign lat  = (|diff[TIME_W-1:LAT_W]) ? '1 : diff[LAT_W-1:0];

    assign cur_cnt = r_cnt[r_cls];
    assign cur_sum = r_sum[r_cls];
    assign cur_min = r_min[r_cls];
    assign cur_max = r_max[r_cls];
    assign sum_ext = {1'b0, cur_sum} + (SUM_W + 1)'(lat);
    assign n_sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign n_cnt   = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
    assign n_min   = (cur_cnt == '0 || lat < cur_min) ? lat : cur_min;
    assign n_max   = (cur_cnt == '0 || lat > cur_max) ? lat : cur_max;

    assign stat_upd = (r_state == S_PROC) && (r_req == REQ_COMPLETE) && r_hit;

    always_comb begin
        tbl_wr.en         = 1'b0;
        tbl_wr.addr       = entry_addr(r_cls, r_hit ? r_hit_idx : free_idx);
        tbl_wr.data.tag   = r_id;
        tbl_wr.data.start = r_time;
        n_lat             = '0;
        if (r_req == REQ_START) begin
            if (r_hit || free_found) begin
                n_status  = STAT_STORED;
                tbl_wr.en = (r_state == S_PROC);
            end else begin
                n_status  = STAT_FULL;
            end
        end else if (r_hit) begin
            n_status = STAT_MEASURED;
            n_lat    = lat;
        end else begin
            n_status = STAT_NOT_FOUND;
        end
    end

    assign div_start = (r_state == S_DIV_GO);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (hit_now || last_cmp) n_state = S_PROC;
            end
            S_PROC: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '{default: '0};
            r_sum       <= '{default: '0};
            r_min       <= '{default: '0};
            r_max       <= '{default: '0};
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (stat_upd) begin
                r_cnt[r_cls] <= n_cnt;
                r_sum[r_cls] <= n_sum;
                r_min[r_cls] <= n_min;
                r_max[r_cls] <= n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_req     <= i_req_type;
                    r_cls     <= i_event_class;
                    r_id      <= i_event_id;
                    r_time    <= i_time_us;
                    r_idx     <= '0;
                    r_cmp_vld <= 1'b0;
                    r_hit     <= 1'b0;
                end
            end
            S_SEARCH: begin
                r_cmp_vld <= rd_en;
                r_cmp_idx <= r_idx[IDX_W-1:0];
                if (rd_en) r_idx <= r_idx + 1'b1;
                if (hit_now) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_start   <= rd_data.start;
                end
            end
            S_PROC: begin
                r_status <= n_status;
                r_lat    <= n_lat;
            end
            S_DIV_GO: begin
            end
            S_DIV_WAIT: begin
                if (div_done) r_avg <= div_quot;
            end
            S_DONE: begin
                if (out_free) begin
                    r_o_status <= r_status;
                    r_o_lat    <= r_lat;
                    r_o_cnt    <= cur_cnt;
                    r_o_min    <= cur_min;
                    r_o_max    <= cur_max;
                    r_o_avg    <= r_avg;
                end
            end
            default: begin
            end
        endcase
    end

    elm_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (tbl_wr),
        .o_rd_data (rd_data),
        .o_valid   (valid)
    );

    elm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cur_sum),
        .i_divisor  (cur_cnt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_latency_us   = r_o_lat;
    assign o_class_count  = r_o_cnt;
    assign o_class_min_us = r_o_min;
    assign o_class_max_us = r_o_max;
    assign o_class_avg_us = r_o_avg;

    a_accept_to_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SEARCH))
        else $error("accepted request did not start the search");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_count_no_decrease: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt[0] >= $past(r_cnt[0]) && r_cnt[1] >= $past(r_cnt[1])))
        else $error("latency count decreased");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] == '0 || r_min[0] <= r_max[0]) && (r_cnt[1] == '0 || r_min[1] <= r_max[1]))
        else $error("class min above class max");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done state");

endmodule

>>> verif/elm_latency_checker.sv
// elm_latency_checker: watches both channels of the event latency monitor and
// predicts every result from its own copy of the id tables and class statistics
// depends on elm_pkg
`timescale 1ns / 1ps

module elm_latency_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_req_type,
    input  logic                       i_event_class,
    input  logic [elm_pkg::ID_W-1:0]   i_event_id,
    input  logic [elm_pkg::TIME_W-1:0] i_time_us,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_status,
    input  logic [elm_pkg::LAT_W-1:0]  i_latency_us,
    input  logic [elm_pkg::LAT_W-1:0]  i_class_count,
    input  logic [elm_pkg::LAT_W-1:0]  i_class_min_us,
    input  logic [elm_pkg::LAT_W-1:0]  i_class_max_us,
    input  logic [elm_pkg::LAT_W-1:0]  i_class_avg_us,
    output int                         o_failures,
    output int                         o_pending,
    output int                         o_checked
);
    import elm_pkg::*;

    localparam int SLOTS = ENTRIES_PER_CLASS;

    typedef struct packed {
        t_status          status;
        logic [LAT_W-1:0] latency;
        logic [LAT_W-1:0] count;
        logic [LAT_W-1:0] min_us;
        logic [LAT_W-1:0] max_us;
        logic [LAT_W-1:0] avg_us;
    } t_latency_report;

    logic              slot_used  [2][SLOTS];
    logic [ID_W-1:0]   slot_id    [2][SLOTS];
    logic [TIME_W-1:0] slot_start [2][SLOTS];
    logic [LAT_W-1:0]  class_count [2];
    logic [SUM_W-1:0]  class_sum   [2];
    logic [LAT_W-1:0]  class_min   [2];
    logic [LAT_W-1:0]  class_max   [2];

    t_latency_report expected_reports [$];
    t_latency_report want;
    int              failures = 0;
    int              checked  = 0;

    initial o_pending = 0;
    assign o_failures = failures;
    assign o_checked  = checked;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
        failures++;
    endtask

    function automatic t_latency_report predict_report(input logic req, input logic cls,
            input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
        t_latency_report   rep;
        int                slot;
        logic [TIME_W-1:0] span;
        logic [SUM_W-1:0]  lat_wide;
        logic [SUM_W-1:0]  avg;
        rep  = '0;
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (slot_used[cls][i] && slot_id[cls][i] == id)
                slot = i;
        if (req == REQ_START) begin
            if (slot < 0)
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_used[cls][i])
                        slot = i;
            if (slot < 0) begin
                rep.status = STAT_FULL;
            end else begin
                slot_used[cls][slot]  = 1'b1;
                slot_id[cls][slot]    = id;
                slot_start[cls][slot] = now;
                rep.status = STAT_STORED;
            end
        end else if (slot < 0) begin
            rep.status = STAT_NOT_FOUND;
        end else begin
            span = now - slot_start[cls][slot];
            rep.latency = (span > 48'h0000_FFFF_FFFF) ? '1 : span[LAT_W-1:0];
            if (class_count[cls] == 0) begin
                class_min[cls] = rep.latency;
                class_max[cls] = rep.latency;
            end else begin
                if (rep.latency < class_min[cls])
                    class_min[cls] = rep.latency;
                if (rep.latency > class_max[cls])
                    class_max[cls] = rep.latency;
            end
            if (class_count[cls] != '1)
                class_count[cls] = class_count[cls] + 1;
            lat_wide = {32'd0, rep.latency};
            if (class_sum[cls] > ~lat_wide)
                class_sum[cls] = '1;
            else
                class_sum[cls] = class_sum[cls] + lat_wide;
            rep.status = STAT_MEASURED;
        end
        rep.count  = class_count[cls];
        rep.min_us = class_min[cls];
        rep.max_us = class_max[cls];
        if (class_count[cls] != 0) begin
            avg = class_sum[cls] / {32'd0, class_count[cls]};
            rep.avg_us = (avg > 64'h0000_0000_FFFF_FFFF) ? '1 : avg[LAT_W-1:0];
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < SLOTS; i++)
                    slot_used[c][i] = 1'b0;
                class_count[c] = '0;
                class_sum[c]   = '0;
                class_min[c]   = '0;
                class_max[c]   = '0;
            end
            expected_reports.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_reports = {expected_reports,
                                    predict_report(i_req_type, i_event_class,
                                                   i_event_id, i_time_us)};
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected result", {62'd0, i_status}, '0);
                end else begin
                    want = expected_reports.pop_front();
                    checked++;
                    if (i_status !== want.status)
                        report_mismatch("status", {62'd0, i_status}, {62'd0, want.status});
                    if (i_latency_us !== want.latency)
                        report_mismatch("latency_us", {32'd0, i_latency_us},
                                        {32'd0, want.latency});
                    if (i_class_count !== want.count)
                        report_mismatch("class_count", {32'd0, i_class_count},
                                        {32'd0, want.count});
                    if (i_class_min_us !== want.min_us)
                        report_mismatch("class_min_us", {32'd0, i_class_min_us},
                                        {32'd0, want.min_us});
                    if (i_class_max_us !== want.max_us)
                        report_mismatch("class_max_us", {32'd0, i_class_max_us},
                                        {32'd0, want.max_us});
                    if (i_class_avg_us !== want.avg_us)
                        report_mismatch("class_avg_us", {32'd0, i_class_avg_us},
                                        {32'd0, want.avg_us});
                end
            end
        end
        o_pending <= expected_reports.size();
    end

endmodule

>>> verif/event_latency_monitor_tb.sv
// event_latency_monitor_tb: clock, reset and request stimulus for the event latency
// monitor, with random idling on both channels and a watchdog
// depends on elm_pkg, event_latency_monitor and elm_latency_checker
`timescale 1ns / 1ps

module event_latency_monitor_tb;
    import elm_pkg::*;

    localparam int RANDOM_REQUESTS = 1875;
    localparam int POOL_SIZE       = 20;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 60;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              in_valid      = 1'b0;
    logic              req_type      = REQ_START;
    logic              event_class   = 1'b0;
    logic [ID_W-1:0]   event_id      = '0;
    logic [TIME_W-1:0] time_us       = '0;
    logic              out_stall     = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_status;
    logic [LAT_W-1:0]  o_latency_us;
    logic [LAT_W-1:0]  o_class_count;
    logic [LAT_W-1:0]  o_class_min_us;
    logic [LAT_W-1:0]  o_class_max_us;
    logic [LAT_W-1:0]  o_class_avg_us;

    int                failures;
    int                pending;
    int                checked;
    int                requests_sent = 0;
    int                directed_sent = 0;
    int                quiet_cycles  = 0;
    int                stall_left    = 0;
    bit                idle_on       = 1'b1;
    logic [TIME_W-1:0] wall_us       = 48'h0000_7FFF_0000;
    logic [ID_W-1:0]   id_pool [2][POOL_SIZE];

    always #1 i_clk = ~i_clk;

    event_latency_monitor u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (req_type),
        .i_event_class  (event_class),
        .i_event_id     (event_id),
        .i_time_us      (time_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_status       (o_status),
        .o_latency_us   (o_latency_us),
        .o_class_count  (o_class_count),
        .o_class_min_us (o_class_min_us),
        .o_class_max_us (o_class_max_us),
        .o_class_avg_us (o_class_avg_us)
    );

    elm_latency_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (req_type),
        .i_event_class  (event_class),
        .i_event_id     (event_id),
        .i_time_us      (time_us),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .i_status       (o_status),
        .i_latency_us   (o_latency_us),
        .i_class_count  (o_class_count),
        .i_class_min_us (o_class_min_us),
        .i_class_max_us (o_class_max_us),
        .i_class_avg_us (o_class_avg_us),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[event_latency_monitor] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic req, input logic cls,
                                input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        event_class <= cls;
        event_id    <= id;
        time_us     <= stamp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        requests_sent++;
    endtask

    // mostly small steps, sometimes long gaps, now and then a jump close to wrap
    task automatic advance_wall_clock();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            wall_us = wall_us + TIME_W'($urandom_range(0, 5000));
        else if (pick < 93)
            wall_us = wall_us + TIME_W'($urandom);
        else if (pick < 97)
            wall_us = wall_us + {16'($urandom_range(1, 16'hFFFF)), 32'h0};
        else
            wall_us = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 10000));
    endtask

    initial begin
        logic [63:0] raw;
        logic        cls;
        logic        req;
        logic [ID_W-1:0] id;
        int          pick;

        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[0][i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
            id_pool[1][i] = (i < ENTRIES_PER_CLASS) ? ID_W'(i) : $urandom;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_COMPLETE, 1'b0, 32'h1234_5678, 48'd10);
        send_request(REQ_START,    1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(REQ_COMPLETE, 1'b0, 32'hFFFF_FFFF, 48'd5);
        send_request(REQ_START,    1'b0, 32'hFFFF_FFFF, 48'd0);
        send_request(REQ_COMPLETE, 1'b0, 32'hFFFF_FFFF, 48'd0);
        send_request(REQ_START,    1'b1, 32'h0,         48'd0);
        send_request(REQ_COMPLETE, 1'b1, 32'h0,         48'h0000_FFFF_FFFF);
        send_request(REQ_COMPLETE, 1'b1, 32'h0,         48'h0001_0000_0000);
        // fill the class 1 table, then a new id and a repeated id in a full table
        for (int i = 1; i < ENTRIES_PER_CLASS; i++)
            send_request(REQ_START, 1'b1, ID_W'(i), 48'h8000_0000_0000 + TIME_W'(i));
        send_request(REQ_START,    1'b1, ID_W'(ENTRIES_PER_CLASS), 48'h8000_0000_1000);
        send_request(REQ_COMPLETE, 1'b1, ID_W'(ENTRIES_PER_CLASS), 48'h8000_0000_2000);
        send_request(REQ_START,    1'b1, 32'h0, wall_us);
        directed_sent = requests_sent;

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 150 == 0)
                idle_on <= (n + 300 < RANDOM_REQUESTS) && ($urandom_range(0, 3) != 0);
            cls  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            id   = id_pool[cls][$urandom_range(0, POOL_SIZE - 1)];
            raw  = {$urandom, $urandom};
            if (pick < 4) begin
                send_request(REQ_COMPLETE, cls, $urandom, raw[TIME_W-1:0]);
            end else if (pick < 8) begin
                send_request(1'($urandom_range(0, 1)), cls, id, raw[TIME_W-1:0]);
            end else begin
                req = ($urandom_range(0, 99) < 55) ? REQ_COMPLETE : REQ_START;
                advance_wall_clock();
                send_request(req, cls, id, wall_us);
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests (%0d directed, the rest random over per-class id pools)",
                 requests_sent, directed_sent);
        $display("checked %0d results, %0d mismatches", checked, failures);
        if (failures == 0 && pending == 0)
            $display("[event_latency_monitor] OK");
        else
            $display("[event_latency_monitor] ERROR");
        $finish;
    end

endmodule

>>> event_latency_monitor.f
hw/rtl/elm_pkg.sv
hw/rtl/elm_table.sv
hw/rtl/elm_div.sv
hw/rtl/event_latency_monitor.sv
verif/elm_latency_checker.sv
verif/event_latency_monitor_tb.sv
